/* rtl/ezp_pkg.sv */
package ezp_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int POS_BITS       = 32;
  localparam int WORK_FRAC      = 30;
  localparam int CORDIC_ITERS   = 30;
  localparam int XW             = 34;  // cordic x, y
  localparam int ZW             = 34;  // cordic residual angle
  localparam int SCW            = 32;  // sine / cosine Q.30
  localparam int CW             = COEF_FRAC_BITS + 2;
  localparam int VW             = 68;  // Q.60 sums
  localparam int RND_SHIFT      = 2 * WORK_FRAC - COEF_FRAC_BITS;
  localparam int RW             = VW - RND_SHIFT;

  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
    logic [POS_BITS-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  // lane 0 roll, lane 1 pitch, lane 2 yaw
  typedef struct packed {
    lane_t [2:0] lane;
    logic  [2:0] flip;
    pos_t        pos;
  } cell_data_t;

  function automatic logic signed [ZW-1:0] atan_of(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;  5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;  5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;  5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;  5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;  5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;  5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;  5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;  5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;  5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;  5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({{(ZW-32){1'b0}}, v});
  endfunction

  // Q.60 to Q1.COEF_FRAC_BITS: round half up, then clamp to +-1.0
  function automatic logic signed [CW-1:0] to_coef(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] one;
    t   = v + (VW'(1) <<< (RND_SHIFT - 1));
    r   = RW'(t >>> RND_SHIFT);
    one = RW'(1) <<< COEF_FRAC_BITS;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return CW'(r);
  endfunction

endpackage

/* rtl/ezp_cordic_cell.sv */
module ezp_cordic_cell
  import ezp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] iter,
  input  logic       up_valid,
  output logic       up_ready,
  input  cell_data_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cell_data_t dn_data
);

  logic       valid_r, valid_nxt;
  cell_data_t data_r, data_nxt;
  logic signed [ZW-1:0] atan;

  assign atan     = atan_of(iter);
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt = up_data;
    for (int k = 0; k < 3; k++) begin
      if (!up_data.lane[k].z[ZW-1]) begin
        data_nxt.lane[k].x = up_data.lane[k].x - (up_data.lane[k].y >>> iter);
        data_nxt.lane[k].y = up_data.lane[k].y + (up_data.lane[k].x >>> iter);
        data_nxt.lane[k].z = up_data.lane[k].z - atan;
      end else begin
        data_nxt.lane[k].x = up_data.lane[k].x + (up_data.lane[k].y >>> iter);
        data_nxt.lane[k].y = up_data.lane[k].y - (up_data.lane[k].x >>> iter);
        data_nxt.lane[k].z = up_data.lane[k].z + atan;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) valid_nxt = up_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* rtl/euler_zyx_to_pose_matrix_unit.sv */
// Pose to 3x4 transform, R = Rz(yaw) * Ry(pitch) * Rx(roll).
// Input channel: in_valid / in_stall with pos_x/y/z and roll/pitch/yaw
// binary angles (32768 = pi). Output channel: out_valid / out_stall with
// r00..r22 in Q1.14, clamped to +-1.0, and the translation copied through.
// One result per item, in order.
// From acceptance to out_valid an item passes through 36 register stages:
// one fold stage, a chain of 30 CORDIC cells (one iteration each, all three
// angles side by side), one sign stage, three multiply / round stages and the
// output register. The fold stage loads on the accepting edge itself.
// Throughput: one item per cycle while out_stall is low; every stage is a register slice.
// A stage refills as soon as its item moves on, so bubbles close up and the
// block keeps taking items while a result waits at the output.
// When the receiver stalls, the output holds and the chain fills up; once
// all stages hold items, in_stall rises.
// Reset clears all valid bits; the chain comes out empty and in_stall low.
module euler_zyx_to_pose_matrix_unit
  import ezp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POS_BITS-1:0]  in_pos_x,
  input  logic signed [POS_BITS-1:0]  in_pos_y,
  input  logic signed [POS_BITS-1:0]  in_pos_z,
  input  logic signed [15:0]          in_roll_angle,
  input  logic signed [15:0]          in_pitch_angle,
  input  logic signed [15:0]          in_yaw_angle,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [CW-1:0]        out_r00,
  output logic signed [CW-1:0]        out_r01,
  output logic signed [CW-1:0]        out_r02,
  output logic signed [CW-1:0]        out_r10,
  output logic signed [CW-1:0]        out_r11,
  output logic signed [CW-1:0]        out_r12,
  output logic signed [CW-1:0]        out_r20,
  output logic signed [CW-1:0]        out_r21,
  output logic signed [CW-1:0]        out_r22,
  output logic signed [POS_BITS-1:0]  out_x,
  output logic signed [POS_BITS-1:0]  out_y,
  output logic signed [POS_BITS-1:0]  out_z
);

  typedef struct packed {
    logic signed [SCW-1:0] sr, cr, sp, cp, sy, cy;
    pos_t pos;
  } sc_t;

  typedef struct packed {
    logic signed [2*SCW-1:0] cycp, sycp, cpsr, cpcr, spsr, spcr;
    logic signed [SCW-1:0]   sr, cr, sp, sy, cy;
    pos_t pos;
  } m1_t;

  typedef struct packed {
    logic signed [2*SCW-1:0] cycp, sycp, cpsr, cpcr;
    logic signed [SCW+1:0]   spsr, spcr;
    logic signed [SCW-1:0]   sr, cr, sp, sy, cy;
    pos_t pos;
  } m2_t;

  typedef struct packed {
    logic signed [2*SCW-1:0] cycp, sycp, cpsr, cpcr;
    logic signed [2*SCW+1:0] cy_spsr, sy_cr, sy_sr, cy_spcr, cy_cr, sy_spsr, sy_spcr, cy_sr;
    logic signed [SCW-1:0]   sp;
    pos_t pos;
  } m3_t;

  typedef struct packed {
    logic signed [CW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    pos_t pos;
  } res_t;

  // ---------------- fold stage ----------------
  logic       p_valid_r, p_ready;
  cell_data_t p_data_r, p_data_nxt;
  logic signed [15:0] ang [3];

  assign ang[0] = in_roll_angle;
  assign ang[1] = in_pitch_angle;
  assign ang[2] = in_yaw_angle;

  always_comb begin
    logic [31:0] a;
    logic        fl;
    p_data_nxt.pos.x = in_pos_x;
    p_data_nxt.pos.y = in_pos_y;
    p_data_nxt.pos.z = in_pos_z;
    for (int k = 0; k < 3; k++) begin
      a  = {ang[k][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
      fl = a[31] ^ a[30];
      // add a half turn in the middle quadrants
      a[31] = a[31] ^ fl;
      p_data_nxt.flip[k]   = fl;
      p_data_nxt.lane[k].x = CORDIC_X0;
      p_data_nxt.lane[k].y = '0;
      p_data_nxt.lane[k].z = ZW'($signed(a));
    end
  end

  // ---------------- cordic chain ----------------
  logic       c_valid [CORDIC_ITERS+1];
  logic       c_ready [CORDIC_ITERS+1];
  cell_data_t c_data  [CORDIC_ITERS+1];

  assign c_valid[0] = p_valid_r;
  assign c_data[0]  = p_data_r;
  assign p_ready    = !p_valid_r || c_ready[0];
  assign in_stall   = !p_ready;

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
    ezp_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .iter     (5'(i)),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_data  (c_data[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_data  (c_data[i+1])
    );
  end

  // ---------------- sign, multiply, round stages ----------------
  logic f_valid_r, m1_valid_r, m2_valid_r, m3_valid_r, o_valid_r;
  logic f_ready, m1_ready, m2_ready, m3_ready, o_ready;
  sc_t  f_r, f_nxt;
  m1_t  m1_r, m1_nxt;
  m2_t  m2_r, m2_nxt;
  m3_t  m3_r, m3_nxt;
  res_t o_r, o_nxt;
  cell_data_t cd;

  assign cd = c_data[CORDIC_ITERS];

  assign o_ready  = !o_valid_r || !out_stall;
  assign m3_ready = !m3_valid_r || o_ready;
  assign m2_ready = !m2_valid_r || m3_ready;
  assign m1_ready = !m1_valid_r || m2_ready;
  assign f_ready  = !f_valid_r || m1_ready;
  assign c_ready[CORDIC_ITERS] = f_ready;

  always_comb begin
    logic signed [SCW-1:0] s [3];
    logic signed [SCW-1:0] c [3];
    for (int k = 0; k < 3; k++) begin
      c[k] = SCW'(cd.lane[k].x);
      s[k] = SCW'(cd.lane[k].y);
      if (cd.flip[k]) begin
        c[k] = -c[k];
        s[k] = -s[k];
      end
    end
    f_nxt.sr  = s[0];
    f_nxt.cr  = c[0];
    f_nxt.sp  = s[1];
    f_nxt.cp  = c[1];
    f_nxt.sy  = s[2];
    f_nxt.cy  = c[2];
    f_nxt.pos = cd.pos;
  end

  always_comb begin
    m1_nxt.cycp = f_r.cy * f_r.cp;
    m1_nxt.sycp = f_r.sy * f_r.cp;
    m1_nxt.cpsr = f_r.cp * f_r.sr;
    m1_nxt.cpcr = f_r.cp * f_r.cr;
    m1_nxt.spsr = f_r.sp * f_r.sr;
    m1_nxt.spcr = f_r.sp * f_r.cr;
    m1_nxt.sr   = f_r.sr;
    m1_nxt.cr   = f_r.cr;
    m1_nxt.sp   = f_r.sp;
    m1_nxt.sy   = f_r.sy;
    m1_nxt.cy   = f_r.cy;
    m1_nxt.pos  = f_r.pos;
  end

  always_comb begin
    logic signed [2*SCW-1:0] half;
    half        = (2*SCW)'(1) <<< (WORK_FRAC - 1);
    m2_nxt.cycp = m1_r.cycp;
    m2_nxt.sycp = m1_r.sycp;
    m2_nxt.cpsr = m1_r.cpsr;
    m2_nxt.cpcr = m1_r.cpcr;
    // round sp*sr and sp*cr back to Q.30
    m2_nxt.spsr = (SCW+2)'((m1_r.spsr + half) >>> WORK_FRAC);
    m2_nxt.spcr = (SCW+2)'((m1_r.spcr + half) >>> WORK_FRAC);
    m2_nxt.sr   = m1_r.sr;
    m2_nxt.cr   = m1_r.cr;
    m2_nxt.sp   = m1_r.sp;
    m2_nxt.sy   = m1_r.sy;
    m2_nxt.cy   = m1_r.cy;
    m2_nxt.pos  = m1_r.pos;
  end

  always_comb begin
    m3_nxt.cycp    = m2_r.cycp;
    m3_nxt.sycp    = m2_r.sycp;
    m3_nxt.cpsr    = m2_r.cpsr;
    m3_nxt.cpcr    = m2_r.cpcr;
    m3_nxt.cy_spsr = m2_r.cy * m2_r.spsr;
    m3_nxt.sy_cr   = (2*SCW+2)'(m2_r.sy * m2_r.cr);
    m3_nxt.sy_sr   = (2*SCW+2)'(m2_r.sy * m2_r.sr);
    m3_nxt.cy_spcr = m2_r.cy * m2_r.spcr;
    m3_nxt.cy_cr   = (2*SCW+2)'(m2_r.cy * m2_r.cr);
    m3_nxt.sy_spsr = m2_r.sy * m2_r.spsr;
    m3_nxt.sy_spcr = m2_r.sy * m2_r.spcr;
    m3_nxt.cy_sr   = (2*SCW+2)'(m2_r.cy * m2_r.sr);
    m3_nxt.sp      = m2_r.sp;
    m3_nxt.pos     = m2_r.pos;
  end

  always_comb begin
    o_nxt.r00 = to_coef(VW'(m3_r.cycp));
    o_nxt.r01 = to_coef(VW'(m3_r.cy_spsr) - VW'(m3_r.sy_cr));
    o_nxt.r02 = to_coef(VW'(m3_r.sy_sr) + VW'(m3_r.cy_spcr));
    o_nxt.r10 = to_coef(VW'(m3_r.sycp));
    o_nxt.r11 = to_coef(VW'(m3_r.cy_cr) + VW'(m3_r.sy_spsr));
    o_nxt.r12 = to_coef(VW'(m3_r.sy_spcr) - VW'(m3_r.cy_sr));
    o_nxt.r20 = to_coef((-VW'(m3_r.sp)) <<< WORK_FRAC);
    o_nxt.r21 = to_coef(VW'(m3_r.cpsr));
    o_nxt.r22 = to_coef(VW'(m3_r.cpcr));
    o_nxt.pos = m3_r.pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r  <= 1'b0;
      f_valid_r  <= 1'b0;
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (p_ready)  p_valid_r  <= in_valid;
      if (f_ready)  f_valid_r  <= c_valid[CORDIC_ITERS];
      if (m1_ready) m1_valid_r <= f_valid_r;
      if (m2_ready) m2_valid_r <= m1_valid_r;
      if (m3_ready) m3_valid_r <= m2_valid_r;
      if (o_ready)  o_valid_r  <= m3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && in_valid) p_data_r <= p_data_nxt;
    if (f_ready && c_valid[CORDIC_ITERS]) f_r <= f_nxt;
    if (m1_ready && f_valid_r) m1_r <= m1_nxt;
    if (m2_ready && m1_valid_r) m2_r <= m2_nxt;
    if (m3_ready && m2_valid_r) m3_r <= m3_nxt;
    if (o_ready && m3_valid_r) o_r <= o_nxt;
  end

  assign out_valid = o_valid_r;
  assign out_r00   = o_r.r00;
  assign out_r01   = o_r.r01;
  assign out_r02   = o_r.r02;
  assign out_r10   = o_r.r10;
  assign out_r11   = o_r.r11;
  assign out_r12   = o_r.r12;
  assign out_r20   = o_r.r20;
  assign out_r21   = o_r.r21;
  assign out_r22   = o_r.r22;
  assign out_x     = o_r.pos.x;
  assign out_y     = o_r.pos.y;
  assign out_z     = o_r.pos.z;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> p_valid_r)
    else $error("accepted item missing from fold stage");

  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_r00 <= 16'sd16384) && (out_r00 >= -16'sd16384)
               && (out_r11 <= 16'sd16384) && (out_r11 >= -16'sd16384))
    else $error("coefficient beyond +-1.0");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> p_valid_r && out_valid && out_stall)
    else $error("input stalled with room in the chain");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("chain not empty after reset");
`endif

endmodule
